### rtl/core/ctsw_pkg.sv
package ctsw_pkg;

  localparam int unsigned MAX_TASKS_DEF  = 16;
  localparam int unsigned COUNT_BITS_DEF = 8;

  localparam int unsigned ID_W     = 4;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TASK  = 1'b1;

  typedef enum logic [1:0] {
    OP_WAIT    = 2'd0,
    OP_SIGNAL  = 2'd1,
    OP_SUSPEND = 2'd2,
    OP_ADMIT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEADLOCK = 2'd1,
    ST_FULL     = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    op_e             opcode;
    logic [ID_W-1:0] task_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]    running_task;
    logic               switched;
    status_e            status;
    logic [CNT_W-1:0]   sem_count;
    logic [DEPTH_W-1:0] waiting_depth;
    logic [DEPTH_W-1:0] ready_depth;
  } out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // transaction accepted: latch item, read queue heads
    logic commit;   // apply update and load result register
  } ctrl_cmd_t;

endpackage

### rtl/core/ctsw_ram.sv
module ctsw_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ctsw_ctrl.sv
module ctsw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ctsw_pkg::ctrl_cmd_t   cmd_o
);

  import ctsw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == S_EXEC) && out_free;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/ctsw_dp.sv
module ctsw_dp #(
  parameter int unsigned MAX_TASKS  = ctsw_pkg::MAX_TASKS_DEF,
  parameter int unsigned COUNT_BITS = ctsw_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ctsw_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  ctsw_pkg::in_t                 in_data_i,
  input  ctsw_pkg::ctrl_cmd_t           cmd_i,
  output ctsw_pkg::out_t                out_data_o
);

  import ctsw_pkg::*;

  localparam int unsigned PTR_W  = $clog2(MAX_TASKS);
  localparam int unsigned FILL_W = $clog2(MAX_TASKS + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_TASKS);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(MAX_TASKS - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  in_t                   item_q;
  logic [COUNT_BITS-1:0] sem_q, sem_d;
  logic [ID_W-1:0]       run_q, run_d;
  logic [PTR_W-1:0]      rhead_q, rhead_d, rtail_q, rtail_d;
  logic [PTR_W-1:0]      whead_q, whead_d, wtail_q, wtail_d;
  logic [FILL_W-1:0]     rfill_q, rfill_d, wfill_q, wfill_d;
  out_t                  out_q;

  logic            rq_we, wq_we;
  logic [ID_W-1:0] rq_wdata, wq_wdata;
  logic [ID_W-1:0] rq_rdata, wq_rdata;
  logic            switched;
  status_e         status;

  ctsw_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (rq_we && cmd_i.commit),
    .waddr_i (rtail_q),
    .wdata_i (rq_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (rhead_q),
    .rdata_o (rq_rdata)
  );

  ctsw_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wq_we && cmd_i.commit),
    .waddr_i (wtail_q),
    .wdata_i (wq_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (whead_q),
    .rdata_o (wq_rdata)
  );

  // one operation, using the head entries read at capture
  always_comb begin
    sem_d    = sem_q;
    run_d    = run_q;
    rhead_d  = rhead_q;
    rtail_d  = rtail_q;
    rfill_d  = rfill_q;
    whead_d  = whead_q;
    wtail_d  = wtail_q;
    wfill_d  = wfill_q;
    rq_we    = 1'b0;
    wq_we    = 1'b0;
    rq_wdata = item_q.task_id;
    wq_wdata = run_q;
    switched = 1'b0;
    status   = ST_OK;
    unique case (item_q.opcode)
      OP_WAIT: begin
        if (sem_q != '0) begin
          sem_d = sem_q - COUNT_BITS'(1);
        end else if (rfill_q == '0) begin
          status = ST_DEADLOCK;
        end else if (wfill_q == FILL_FULL) begin
          status = ST_FULL;
        end else begin
          rhead_d  = ptr_inc(rhead_q);
          rfill_d  = rfill_q - FILL_W'(1);
          wq_we    = 1'b1;
          wtail_d  = ptr_inc(wtail_q);
          wfill_d  = wfill_q + FILL_W'(1);
          run_d    = rq_rdata;
          switched = 1'b1;
        end
      end
      OP_SIGNAL: begin
        if (wfill_q == '0) begin
          if (&sem_q) begin
            status = ST_SAT;
          end else begin
            sem_d = sem_q + COUNT_BITS'(1);
          end
        end else if (rfill_q == FILL_FULL) begin
          status = ST_FULL;
        end else begin
          whead_d  = ptr_inc(whead_q);
          wfill_d  = wfill_q - FILL_W'(1);
          rq_we    = 1'b1;
          rq_wdata = wq_rdata;
          rtail_d  = ptr_inc(rtail_q);
          rfill_d  = rfill_q + FILL_W'(1);
        end
      end
      OP_SUSPEND: begin
        // head was read before the tail write, so a full queue rotates too
        if (rfill_q != '0) begin
          rhead_d  = ptr_inc(rhead_q);
          rq_we    = 1'b1;
          rq_wdata = run_q;
          rtail_d  = ptr_inc(rtail_q);
          run_d    = rq_rdata;
          switched = 1'b1;
        end
      end
      OP_ADMIT: begin
        if (rfill_q == FILL_FULL) begin
          status = ST_FULL;
        end else begin
          rq_we   = 1'b1;
          rtail_d = ptr_inc(rtail_q);
          rfill_d = rfill_q + FILL_W'(1);
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q.running_task  <= run_d;
      out_q.switched      <= switched;
      out_q.status        <= status;
      out_q.sem_count     <= CNT_W'(sem_d);
      out_q.waiting_depth <= DEPTH_W'(wfill_d);
      out_q.ready_depth   <= DEPTH_W'(rfill_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_q   <= '0;
      run_q   <= '0;
      rhead_q <= '0;
      rtail_q <= '0;
      rfill_q <= '0;
      whead_q <= '0;
      wtail_q <= '0;
      wfill_q <= '0;
    end else if (cmd_i.commit) begin
      sem_q   <= sem_d;
      run_q   <= run_d;
      rhead_q <= rhead_d;
      rtail_q <= rtail_d;
      rfill_q <= rfill_d;
      whead_q <= whead_d;
      wtail_q <= wtail_d;
      wfill_q <= wfill_d;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INIT_COUNT: begin
          sem_q   <= COUNT_BITS'(cfg_wdata_i);
          whead_q <= '0;
          wtail_q <= '0;
          wfill_q <= '0;
        end
        REG_INIT_TASK: run_q <= cfg_wdata_i[ID_W-1:0];
        default: run_q <= run_q;
      endcase
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/counting_semaphore_task_switch.sv
// Task scheduler with one counting semaphore and two FIFO queues.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is
// one operation: wait, signal, suspend, or admit of in_data_i.task_id.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// operation: running task, switch flag, status, count and queue depths.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 = initial count, also empties the wait queue; 1 = initial task).
// Write only while no operation is in flight.
//
// Sequence: an accepted input transaction moves the controller to its
// execute state; the result register and out_valid_o are loaded when the
// execute state ends, which waits until the output register is free.
// Operations do not overlap: in_stall_o is high in the execute state. The
// queue RAMs have a registered read, so the heads are fetched in the accept
// cycle and the update is done in the execute state.
// The result sits in an output register, so a new operation is accepted
// while it waits. If the receiver stalls, the following operation holds in
// its execute state until the output register frees up.
// Reset: count 0, running task 0, both queues empty. Queue RAM contents are
// not cleared; pointers and fill counts alone define what is valid.
module counting_semaphore_task_switch #(
  parameter int unsigned MAX_TASKS  = ctsw_pkg::MAX_TASKS_DEF,
  parameter int unsigned COUNT_BITS = ctsw_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ctsw_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ctsw_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ctsw_pkg::out_t                 out_data_o
);

  import ctsw_pkg::*;

  ctrl_cmd_t cmd;

  // sequencing: accept, execute, hand off to output register
  ctsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // scheduler state, queue RAMs and result register
  ctsw_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule
